[sv/utf8bmp_pkg.sv]
// ----------------------------------------------------------------------------
// utf8bmp_pkg
// Shared types, constants and byte classification for the UTF-8 to
// BMP UTF-16 transcoder.
// ----------------------------------------------------------------------------
package utf8bmp_pkg;

   localparam int UNIT_W = 16;
   localparam int ACC_W  = 31;
   localparam int LEN_W  = 3;

   localparam logic [UNIT_W-1:0] REPL_UNIT      = 16'hFFFD;
   localparam logic [UNIT_W-1:0] CAPACITY_RESET = 16'hFFFF;
   localparam logic [7:0]        CONT_BITS_MASK = 8'h3F;

   typedef enum logic [1:0] {
      CLS_END,
      CLS_ASCII,
      CLS_CONT,
      CLS_LEAD
   } byte_class_type;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              is_terminator;
      logic [UNIT_W-1:0] kept_count;
      logic              last;
   } rsp_type;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type cls;
      if (b == 8'h00) begin
         cls = CLS_END;
      end else if (b[7] == 1'b0) begin
         cls = CLS_ASCII;
      end else if (b[7:6] == 2'b10 || b[7:1] == 7'b1111111) begin
         cls = CLS_CONT;
      end else begin
         cls = CLS_LEAD;
      end
      return cls;
   endfunction

   // sequence length implied by a lead byte (C0-FD)
   function automatic logic [LEN_W-1:0] lead_len(input logic [7:0] b);
      logic [LEN_W-1:0] len;
      priority if (b[7:5] == 3'b110)   len = 3'd2;
      else if (b[7:4] == 4'b1110)      len = 3'd3;
      else if (b[7:3] == 5'b11110)     len = 3'd4;
      else if (b[7:2] == 6'b111110)    len = 3'd5;
      else                             len = 3'd6;
      return len;
   endfunction

   // value bits carried by a lead byte
   function automatic logic [7:0] lead_bits(input logic [7:0] b);
      logic [7:0] v;
      priority if (b[7:5] == 3'b110)   v = b & 8'h1F;
      else if (b[7:4] == 4'b1110)      v = b & 8'h0F;
      else if (b[7:3] == 5'b11110)     v = b & 8'h07;
      else if (b[7:2] == 6'b111110)    v = b & 8'h03;
      else                             v = b & 8'h01;
      return v;
   endfunction

   // surrogates and anything above the BMP become the replacement unit
   function automatic logic [UNIT_W-1:0] to_bmp(input logic [ACC_W-1:0] v);
      logic [UNIT_W-1:0] u;
      if (v[ACC_W-1:UNIT_W] != '0 || v[15:11] == 5'b11011) begin
         u = REPL_UNIT;
      end else begin
         u = v[UNIT_W-1:0];
      end
      return u;
   endfunction

endpackage

[sv/utf8bmp_decoder.sv]
// ----------------------------------------------------------------------------
// utf8bmp_decoder
// Input byte register plus sequence state. Produces at most one result per
// cycle; a broken sequence holds its byte while replacements drain.
// ----------------------------------------------------------------------------
module utf8bmp_decoder
   import utf8bmp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic [UNIT_W-1:0] capacity,
   input  logic              slot_free,
   output logic              push,
   output rsp_type           push_data
);

   logic [7:0]        byte_ff;
   logic              byte_valid_ff, byte_valid_in;
   logic [LEN_W-1:0]  exp_len_ff, exp_len_in;
   logic [LEN_W-1:0]  seen_ff, seen_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [UNIT_W-1:0] count_ff, count_in;

   byte_class_type    cls;
   logic              step;
   logic              done;
   logic              emit;
   logic [UNIT_W-1:0] cap_limit;
   logic              room;
   logic              room_next;
   logic [UNIT_W:0]   count_inc;
   logic [ACC_W-1:0]  acc_shift;
   logic [LEN_W-1:0]  seen_inc;

   assign cls       = classify(byte_ff);
   assign step      = byte_valid_ff && slot_free;
   assign cap_limit = (capacity == '0) ? '0 : capacity - 1'b1;
   assign room      = count_ff < cap_limit;
   assign count_inc = {1'b0, count_ff} + 1'b1;
   assign room_next = count_inc < {1'b0, cap_limit};
   assign acc_shift = {acc_ff[ACC_W-7:0], byte_ff[5:0] & CONT_BITS_MASK[5:0]};
   assign seen_inc  = seen_ff + 1'b1;

   always_comb begin
      exp_len_in = exp_len_ff;
      seen_in    = seen_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      done       = 1'b0;
      emit       = 1'b0;
      push_data  = '{code_unit: REPL_UNIT, is_terminator: 1'b0,
                     kept_count: '0, last: 1'b1};
      if (step) begin
         if (exp_len_ff != '0 && cls == CLS_CONT) begin
            done    = 1'b1;
            acc_in  = acc_shift;
            seen_in = seen_inc;
            if (seen_inc >= exp_len_ff) begin
               emit                = room;
               push_data.code_unit = to_bmp(acc_shift);
               exp_len_in          = '0;
               seen_in             = '0;
               acc_in              = '0;
            end
         end else if (exp_len_ff != '0) begin
            // broken sequence: one replacement per byte taken, byte held
            emit    = room;
            seen_in = seen_ff - 1'b1;
            if (seen_ff == 3'd1) begin
               exp_len_in = '0;
               acc_in     = '0;
            end
            push_data.last = !((seen_ff > 3'd1 && room_next) || cls == CLS_END ||
                               (cls == CLS_ASCII && room_next));
         end else begin
            done = 1'b1;
            unique case (cls)
               CLS_END: begin
                  emit                    = 1'b1;
                  push_data.code_unit     = '0;
                  push_data.is_terminator = 1'b1;
                  push_data.kept_count    = count_ff;
                  count_in                = '0;
               end
               CLS_ASCII: begin
                  emit                = room;
                  push_data.code_unit = {8'h00, byte_ff};
               end
               CLS_CONT: begin
                  emit = room;
               end
               CLS_LEAD: begin
                  exp_len_in = lead_len(byte_ff);
                  seen_in    = 3'd1;
                  acc_in     = {{(ACC_W-8){1'b0}}, lead_bits(byte_ff)};
               end
               default: ;
            endcase
         end
         if (emit && !push_data.is_terminator) begin
            count_in = count_inc[UNIT_W-1:0];
         end
      end
   end

   assign push      = emit;
   assign req_ready = !byte_valid_ff || done;

   always_comb begin
      byte_valid_in = byte_valid_ff;
      if (req_valid && req_ready) begin
         byte_valid_in = 1'b1;
      end else if (done) begin
         byte_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         exp_len_ff    <= '0;
         seen_ff       <= '0;
         acc_ff        <= '0;
         count_ff      <= '0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         exp_len_ff    <= exp_len_in;
         seen_ff       <= seen_in;
         acc_ff        <= acc_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_in_byte;
      end
   end

endmodule

[sv/utf8bmp_out_reg.sv]
// ----------------------------------------------------------------------------
// utf8bmp_out_reg
// Result register; frees its slot in the cycle the consumer takes it.
// ----------------------------------------------------------------------------
module utf8bmp_out_reg
   import utf8bmp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    slot_free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[sv/utf8_to_bmp_utf16_transcoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_bmp_utf16_transcoder
// Decodes UTF-8 bytes into BMP UTF-16 code units with replacement on errors
// and an output capacity limit per string.
//
//   port group   direction   contents
//   req_*        in          one UTF-8 byte, valid/ready
//   rsp_*        out         code unit, terminator flag, kept count, last
//   csr_*        in          output capacity write, no read-back
//
// One byte per cycle unless a sequence breaks or the result register stalls.
// A non-continuation byte in an open sequence is held while one replacement
// unit per byte already taken passes the single result register.
// Reset: capacity 65535, no sequence open, unit count zero.
// A stalled result register stops decoding; the input register still holds
// one byte, so the request side stalls only once both are full.
// ----------------------------------------------------------------------------
module utf8_to_bmp_utf16_transcoder
   import utf8bmp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [UNIT_W-1:0] rsp_code_unit,
   output logic              rsp_is_terminator,
   output logic [UNIT_W-1:0] rsp_kept_count,
   output logic              rsp_last,
   input  logic              csr_wr_en,
   input  logic [UNIT_W-1:0] csr_wr_data
);

   logic [UNIT_W-1:0] capacity_ff;
   logic              slot_free;
   logic              push;
   rsp_type           push_data;
   rsp_type           rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   utf8bmp_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .capacity    (capacity_ff),
      .slot_free   (slot_free),
      .push        (push),
      .push_data   (push_data)
   );

   utf8bmp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_code_unit     = rsp_data.code_unit;
   assign rsp_is_terminator = rsp_data.is_terminator;
   assign rsp_kept_count    = rsp_data.kept_count;
   assign rsp_last          = rsp_data.last;

   a_term_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_terminator |-> rsp_last && rsp_code_unit == '0)
      else $error("terminator result not marked last");

   a_count_only_on_term: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_terminator |-> rsp_kept_count == '0)
      else $error("kept count on a non-terminator result");

   a_no_surrogate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_code_unit >= 16'hD800 && rsp_code_unit <= 16'hDFFF))
      else $error("surrogate code unit emitted");

   a_push_needs_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $past(!push))
      else $error("result register overwritten while stalled");

endmodule

[tb/utf8_to_bmp_utf16_transcoder_tb.sv]
// ----------------------------------------------------------------------------
// utf8_to_bmp_utf16_transcoder_tb
// Self-checking bench for the UTF-8 to BMP UTF-16 transcoder. A directed
// table of byte requests and capacity writes is followed by random phases.
// The random phases are made mostly of well-formed sequences, with strays,
// truncated sequences, surrogate edges and terminators mixed in. Every
// accepted byte goes through a local decoder model, and each response is
// compared field by field, in order. Both handshakes idle at random. One
// long response stall backs the block up into its request side.
// ----------------------------------------------------------------------------
module utf8_to_bmp_utf16_transcoder_tb
   import utf8bmp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned SETTLE_WAIT  = 8;
   localparam int unsigned FINAL_WAIT   = 20;
   localparam int unsigned HOLD_CYCLES  = 60;
   localparam int unsigned PHASE_ITEMS  = 24;

   typedef enum logic {
      ROW_BYTE,
      ROW_CAPACITY
   } row_kind_type;

   // value is the byte or the capacity; unit/term/kept used only when typed
   typedef struct packed {
      row_kind_type      kind;
      logic [15:0]       value;
      logic              typed;
      logic [UNIT_W-1:0] unit;
      logic              term;
      logic [UNIT_W-1:0] kept;
   } stim_row_type;

   localparam stim_row_type DIRECTED [27] = '{
      '{ROW_BYTE,     16'h0041, 1'b1, 16'h0041, 1'b0, 16'd0},
      '{ROW_BYTE,     16'h007F, 1'b1, 16'h007F, 1'b0, 16'd0},
      '{ROW_BYTE,     16'h00FF, 1'b1, 16'hFFFD, 1'b0, 16'd0},   // FF as a stray continuation
      '{ROW_BYTE,     16'h0000, 1'b1, 16'h0000, 1'b1, 16'd3},
      '{ROW_BYTE,     16'h00C0, 1'b0, 16'd0,    1'b0, 16'd0},   // overlong zero
      '{ROW_BYTE,     16'h0080, 1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_BYTE,     16'h00ED, 1'b0, 16'd0,    1'b0, 16'd0},   // D800
      '{ROW_BYTE,     16'h00A0, 1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_BYTE,     16'h0080, 1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_BYTE,     16'h00EF, 1'b0, 16'd0,    1'b0, 16'd0},   // FFFF
      '{ROW_BYTE,     16'h00BF, 1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_BYTE,     16'h00BF, 1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_BYTE,     16'h00FD, 1'b0, 16'd0,    1'b0, 16'd0},   // six bytes, FE/FF inside
      '{ROW_BYTE,     16'h00FE, 1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_BYTE,     16'h00BF, 1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_BYTE,     16'h00BF, 1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_BYTE,     16'h00BF, 1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_BYTE,     16'h00FF, 1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_BYTE,     16'h00E0, 1'b0, 16'd0,    1'b0, 16'd0},   // broken by 01
      '{ROW_BYTE,     16'h0080, 1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_BYTE,     16'h0001, 1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_BYTE,     16'h00F8, 1'b0, 16'd0,    1'b0, 16'd0},   // broken by end
      '{ROW_BYTE,     16'h0000, 1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_CAPACITY, 16'd2,    1'b0, 16'd0,    1'b0, 16'd0},
      '{ROW_BYTE,     16'h0041, 1'b1, 16'h0041, 1'b0, 16'd0},
      '{ROW_BYTE,     16'h0042, 1'b0, 16'd0,    1'b0, 16'd0},   // dropped, capacity reached
      '{ROW_BYTE,     16'h0000, 1'b1, 16'h0000, 1'b1, 16'd1}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_in_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [UNIT_W-1:0] rsp_code_unit;
   logic              rsp_is_terminator;
   logic [UNIT_W-1:0] rsp_kept_count;
   logic              rsp_last;
   logic              csr_wr_en = 1'b0;
   logic [UNIT_W-1:0] csr_wr_data = '0;

   utf8_to_bmp_utf16_transcoder uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_is_terminator (rsp_is_terminator),
      .rsp_kept_count    (rsp_kept_count),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #6 clock = ~clock;

   // decoder model state
   logic [UNIT_W-1:0] cap_reg    = CAPACITY_RESET;
   logic [2:0]        seq_len    = '0;
   logic [2:0]        seq_taken  = '0;
   logic [ACC_W-1:0]  seq_bits   = '0;
   logic [UNIT_W-1:0] kept_units = '0;

   rsp_type           step_units[$];
   rsp_type           expected_units[$];

   int unsigned       send_idle_pct = 17;
   int unsigned       recv_idle_pct = 61;
   int unsigned       error_count   = 0;
   int unsigned       bytes_sent    = 0;
   int unsigned       units_checked = 0;
   int unsigned       ends_checked  = 0;
   int unsigned       cycle_count   = 0;

   logic              req_take  = 1'b0;
   logic              hold_start = 1'b0;
   logic              in_hold    = 1'b0;

   function automatic bit is_cont_byte(input logic [7:0] b);
      return (b >= 8'h80 && b <= 8'hBF) || b >= 8'hFE;
   endfunction

   function automatic logic [UNIT_W-1:0] bmp_unit(input logic [ACC_W-1:0] v);
      if (v > 31'h0000_FFFF || (v >= 31'h0000_D800 && v <= 31'h0000_DFFF)) begin
         return REPL_UNIT;
      end
      return v[UNIT_W-1:0];
   endfunction

   task automatic keep_unit(input logic [UNIT_W-1:0] u);
      rsp_type           r;
      logic [UNIT_W-1:0] limit;
      limit = (cap_reg == '0) ? '0 : cap_reg - 16'd1;
      if (kept_units < limit) begin
         r = '0;
         r.code_unit = u;
         step_units.push_back(r);
         kept_units++;
      end
   endtask

   // fills step_units with the responses one request byte causes
   task automatic decode_byte(input logic [7:0] b);
      rsp_type r;
      step_units.delete();
      if (seq_len != 0 && is_cont_byte(b)) begin
         seq_bits = {seq_bits[ACC_W-7:0], b[5:0]};
         seq_taken++;
         if (seq_taken >= seq_len) begin
            keep_unit(bmp_unit(seq_bits));
            seq_len   = '0;
            seq_taken = '0;
            seq_bits  = '0;
         end
      end else begin
         // a broken sequence pays one replacement per byte taken so far
         if (seq_len != 0) begin
            repeat (seq_taken) keep_unit(REPL_UNIT);
            seq_len   = '0;
            seq_taken = '0;
            seq_bits  = '0;
         end
         if (b == 8'h00) begin
            r = '0;
            r.is_terminator = 1'b1;
            r.kept_count = kept_units;
            step_units.push_back(r);
            kept_units = '0;
         end else if (b < 8'h80) begin
            keep_unit({8'h00, b});
         end else if (is_cont_byte(b)) begin
            keep_unit(REPL_UNIT);
         end else begin
            seq_taken = 3'd1;
            if (b < 8'hE0) begin
               seq_len = 3'd2; seq_bits = ACC_W'(b & 8'h1F);
            end else if (b < 8'hF0) begin
               seq_len = 3'd3; seq_bits = ACC_W'(b & 8'h0F);
            end else if (b < 8'hF8) begin
               seq_len = 3'd4; seq_bits = ACC_W'(b & 8'h07);
            end else if (b < 8'hFC) begin
               seq_len = 3'd5; seq_bits = ACC_W'(b & 8'h03);
            end else begin
               seq_len = 3'd6; seq_bits = ACC_W'(b & 8'h01);
            end
         end
      end
      if (step_units.size() != 0) begin
         r = step_units.pop_back();
         r.last = 1'b1;
         step_units.push_back(r);
      end
   endtask

   // offer one request byte and hold it until accepted; valid stays high after
   task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input rsp_type typed_rsp = '0);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_take) @(posedge clock);
      bytes_sent++;
      decode_byte(b);
      if (typed) begin
         expected_units.push_back(typed_rsp);
      end else begin
         foreach (step_units[i]) expected_units.push_back(step_units[i]);
      end
   endtask

   // drop valid, wait for every expected response, then let trailing bytes clear
   task automatic settle(input int unsigned extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_units.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [UNIT_W-1:0] c);
      settle(SETTLE_WAIT);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_reg = c;
   endtask

   function automatic logic [7:0] cont_byte();
      if ($urandom_range(0, 9) == 0) return 8'hFE | 8'($urandom_range(0, 1));
      return {2'b10, 6'($urandom_range(0, 63))};
   endfunction

   function automatic logic [7:0] lead_for(input int unsigned len);
      case (len)
         2:       return {3'b110,     5'($urandom_range(0, 31))};
         3:       return {4'b1110,    4'($urandom_range(0, 15))};
         4:       return {5'b11110,   3'($urandom_range(0, 7))};
         5:       return {6'b111110,  2'($urandom_range(0, 3))};
         default: return {7'b1111110, 1'($urandom_range(0, 1))};
      endcase
   endfunction

   task automatic send_random_phase(input int unsigned n_items);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned len;
      int unsigned conts;
      stop_at = bytes_sent + n_items;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 3) != 0) ? $urandom_range(2, 3) : $urandom_range(4, 6);
         if (pick < 25) begin
            push_byte(8'($urandom_range(1, 127)));
         end else if (pick < 60) begin
            push_byte(lead_for(len));
            repeat (len - 1) push_byte(cont_byte());
         end else if (pick < 68) begin
            // around the surrogate window: ED 9F xx stays legal, ED A0-BF xx does not
            push_byte(8'hED);
            push_byte(($urandom_range(0, 1) != 0) ?
                      8'h9F : {3'b101, 5'($urandom_range(0, 31))});
            push_byte(cont_byte());
         end else if (pick < 78) begin
            push_byte(8'h00);
         end else if (pick < 86) begin
            push_byte(cont_byte());
         end else if (pick < 93) begin
            // truncated; a next byte that is not a continuation breaks it
            conts = $urandom_range(0, len - 2);
            push_byte(lead_for(len));
            repeat (conts) push_byte(cont_byte());
         end else begin
            push_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // handshake sampling and response checking on the falling clock edge
   always @(negedge clock) begin
      rsp_type exp_rsp;
      req_take = req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_units.size() == 0) begin
            $error("unexpected response: code_unit %h is_terminator %b kept_count %0d",
                   rsp_code_unit, rsp_is_terminator, rsp_kept_count);
            error_count++;
         end else begin
            exp_rsp = expected_units.pop_front();
            if (rsp_code_unit !== exp_rsp.code_unit) begin
               $error("code_unit: expected %h, actual %h", exp_rsp.code_unit, rsp_code_unit);
               error_count++;
            end
            if (rsp_is_terminator !== exp_rsp.is_terminator) begin
               $error("is_terminator: expected %b, actual %b",
                      exp_rsp.is_terminator, rsp_is_terminator);
               error_count++;
            end
            if (rsp_kept_count !== exp_rsp.kept_count) begin
               $error("kept_count: expected %0d, actual %0d",
                      exp_rsp.kept_count, rsp_kept_count);
               error_count++;
            end
            if (rsp_last !== exp_rsp.last) begin
               $error("last: expected %b, actual %b", exp_rsp.last, rsp_last);
               error_count++;
            end
            if (exp_rsp.is_terminator) ends_checked++;
            else units_checked++;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= in_hold ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // long response stall, counted here so the sender keeps pushing meanwhile
   always begin
      @(posedge hold_start);
      in_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      in_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      rsp_type typed_rsp;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_CAPACITY) begin
            set_capacity(DIRECTED[i].value);
         end else begin
            typed_rsp = '0;
            typed_rsp.code_unit     = DIRECTED[i].unit;
            typed_rsp.is_terminator = DIRECTED[i].term;
            typed_rsp.kept_count    = DIRECTED[i].kept;
            typed_rsp.last          = 1'b1;
            push_byte(DIRECTED[i].value[7:0], DIRECTED[i].typed, typed_rsp);
         end
      end

      set_capacity(16'd1);
      send_random_phase(PHASE_ITEMS);
      set_capacity(16'($urandom_range(2, 12)));
      send_random_phase(PHASE_ITEMS);

      send_idle_pct = 61;
      recv_idle_pct <= 17;
      set_capacity(16'd0);
      send_random_phase(PHASE_ITEMS);
      set_capacity(16'($urandom_range(3, 40)));
      send_random_phase(PHASE_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct <= 0;
      set_capacity(16'hFFFF);
      hold_start <= 1'b1;
      send_random_phase(PHASE_ITEMS);
      // lowering capacity with a string possibly still open
      set_capacity(16'($urandom_range(5, 20)));
      send_random_phase(PHASE_ITEMS);

      settle(FINAL_WAIT);
      $display("Run covered %0d request bytes over seven capacity settings,", bytes_sent);
      $display("with %0d code units and %0d string ends checked.", units_checked, ends_checked);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[files.f]
sv/utf8bmp_pkg.sv
sv/utf8bmp_decoder.sv
sv/utf8bmp_out_reg.sv
sv/utf8_to_bmp_utf16_transcoder.sv
tb/utf8_to_bmp_utf16_transcoder_tb.sv
